// ----- src/fet_pkg.sv -----
`default_nettype none

package fet_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 24;
  localparam int OUT_BITS    = 4 * SAMPLE_BITS + 2 * COUNT_BITS;
  localparam int OUT_BYTES   = (OUT_BITS + 7) / 8;
  localparam int OUT_DATA_W  = OUT_BYTES * 8;
  localparam int IN_BYTES    = (SAMPLE_BITS + 7) / 8;
  localparam int IN_DATA_W   = IN_BYTES * 8;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic        [COUNT_BITS-1:0]  count_t;

  // running per-frame tracking state
  typedef struct packed {
    logic    frame_open;
    sample_t lo;
    sample_t lo2;
    logic    lo2_seen;
    sample_t hi;
    sample_t hi2;
    logic    hi2_seen;
    count_t  lo_cnt;
    count_t  hi_cnt;
  } track_t;

  // one frame summary
  typedef struct packed {
    count_t  max_count;
    count_t  min_count;
    sample_t second_max_value;
    sample_t max_value;
    sample_t second_min_value;
    sample_t min_value;
  } summary_t;

endpackage : fet_pkg

`default_nettype wire

// ----- src/fet_update.sv -----
`default_nettype none

module fet_update (
  input  fet_pkg::track_t   st,
  input  fet_pkg::sample_t  pixel,
  input  logic              last,
  output fet_pkg::track_t   st_nxt,
  output fet_pkg::summary_t summary
);
  import fet_pkg::*;

  localparam count_t CNT_ONE = count_t'(1);
  localparam count_t CNT_MAX = {COUNT_BITS{1'b1}};

  track_t upd;

  always_comb begin
    upd = st;
    if (!st.frame_open) begin
      upd.lo       = pixel;
      upd.hi       = pixel;
      upd.lo2      = '0;
      upd.hi2      = '0;
      upd.lo2_seen = 1'b0;
      upd.hi2_seen = 1'b0;
      upd.lo_cnt   = CNT_ONE;
      upd.hi_cnt   = CNT_ONE;
    end else begin
      if (pixel < st.lo) begin
        upd.lo2      = st.lo;
        upd.lo2_seen = 1'b1;
        upd.lo       = pixel;
        upd.lo_cnt   = CNT_ONE;
      end else if (pixel == st.lo) begin
        upd.lo_cnt = (st.lo_cnt == CNT_MAX) ? CNT_MAX : st.lo_cnt + CNT_ONE;
      end else if (!st.lo2_seen || pixel < st.lo2) begin
        upd.lo2      = pixel;
        upd.lo2_seen = 1'b1;
      end

      if (pixel > st.hi) begin
        upd.hi2      = st.hi;
        upd.hi2_seen = 1'b1;
        upd.hi       = pixel;
        upd.hi_cnt   = CNT_ONE;
      end else if (pixel == st.hi) begin
        upd.hi_cnt = (st.hi_cnt == CNT_MAX) ? CNT_MAX : st.hi_cnt + CNT_ONE;
      end else if (!st.hi2_seen || pixel > st.hi2) begin
        upd.hi2      = pixel;
        upd.hi2_seen = 1'b1;
      end
    end
    upd.frame_open = !last;
    st_nxt = upd;
  end

  // constant frame or missing runner-up: second extremum falls back to extremum
  always_comb begin
    summary.min_value        = upd.lo;
    summary.max_value        = upd.hi;
    summary.min_count        = upd.lo_cnt;
    summary.max_count        = upd.hi_cnt;
    summary.second_min_value = upd.lo2_seen ? upd.lo2 : upd.lo;
    summary.second_max_value = upd.hi2_seen ? upd.hi2 : upd.hi;
    if (upd.lo == upd.hi) begin
      summary.second_min_value = upd.lo;
      summary.second_max_value = upd.hi;
    end
  end

endmodule : fet_update

`default_nettype wire

// ----- src/frame_extrema_tracker.sv -----
`default_nettype none
// Frame min/max tracker with runner-up extrema and saturating equal-counts.
// A last pixel's summary word passes through the input register stage, then the output register.
// Throughput: one pixel word per cycle; the only stall is a last pixel whose
// summary cannot enter the output register because the previous one waits.
// Reset (rst_n low, synchronous): both stages empty, next pixel opens a frame.

module frame_extrema_tracker (
  input  logic                         clk,
  input  logic                         rst_n,
  // pixel stream
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [fet_pkg::IN_DATA_W-1:0] in_tdata,  // [15:0] pixel_value
  input  logic                         in_tlast,  // last_pixel
  // frame summary stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [15:0] min_value, [31:16] second_min_value, [47:32] max_value,
  // [63:48] second_max_value, [87:64] min_count, [111:88] max_count
  output logic [fet_pkg::OUT_DATA_W-1:0] out_tdata
);
  import fet_pkg::*;

  // input register stage
  logic     s1_valid_r, s1_valid_nxt;
  sample_t  s1_pix_r;
  logic     s1_last_r;
  logic     s1_adv;

  // tracking state
  track_t   st_r, st_nxt;
  summary_t summary;

  // output register
  logic     out_valid_r, out_valid_nxt;
  summary_t out_data_r;

  logic     in_fire;
  logic     out_free;

  assign out_free = !out_valid_r || out_tready;
  // a non-last pixel never needs the output slot
  assign s1_adv   = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire  = in_tvalid && in_tready;

  fet_update u_update (
    .st      (st_r),
    .pixel   (s1_pix_r),
    .last    (s1_last_r),
    .st_nxt  (st_nxt),
    .summary (summary)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r  <= sample_t'(in_tdata[SAMPLE_BITS-1:0]);
      s1_last_r <= in_tlast;
    end
    if (s1_adv && s1_last_r) begin
      out_data_r <= summary;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_data_r);

endmodule : frame_extrema_tracker

`default_nettype wire

// ----- verif/tb_frame_extrema_tracker.sv -----
module tb_frame_extrema_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  import fet_pkg::*;

  localparam int STALL_MAX      = 3;     // longest idle draw on either side
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side
  localparam int TAIL_CYCLES    = 16;    // pipeline is 2 deep; generous margin
  localparam int RANDOM_PIXELS  = 900;
  localparam int REPORT_LIMIT   = 10;

  // how random pixel values are drawn for one frame
  typedef enum int {PIX_FULL, PIX_NARROW, PIX_EDGES} pixel_mode_t;

  // running per-frame state of the predictor
  typedef struct {
    logic    open;
    sample_t lo;
    sample_t lo_next;
    logic    lo_next_ok;
    sample_t hi;
    sample_t hi_next;
    logic    hi_next_ok;
    count_t  lo_hits;
    count_t  hi_hits;
  } extrema_state_t;

  logic                  clk   = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [15:0] pixel_value
  logic                  in_tlast;   // last_pixel
  logic                  out_tvalid;
  logic                  out_tready;
  // [15:0] min_value, [31:16] second_min_value, [47:32] max_value,
  // [63:48] second_max_value, [87:64] min_count, [111:88] max_count
  logic [OUT_DATA_W-1:0] out_tdata;

  extrema_state_t trk;
  summary_t       summary_q[$];      // frame summaries still owed by the DUT
  bit             gaps_on;           // idling enabled on both sides
  int             pixels_sent;
  int             frames_sent;
  int             summaries_seen;
  int             faults;
  int             quiet_cycles;

  always #2 clk = ~clk;

  frame_extrema_tracker u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  function automatic count_t sat_inc(count_t c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // Advance the predictor by one accepted pixel word; on the last pixel of a
  // frame, queue the summary the DUT must produce.
  task automatic track_pixel(sample_t v, logic last);
    summary_t s;
    if (!trk.open) begin
      // first pixel opens the frame and wipes all tracking
      trk.open       = 1'b1;
      trk.lo         = v;
      trk.hi         = v;
      trk.lo_next    = '0;
      trk.hi_next    = '0;
      trk.lo_next_ok = 1'b0;
      trk.hi_next_ok = 1'b0;
      trk.lo_hits    = count_t'(1);
      trk.hi_hits    = count_t'(1);
    end else begin
      if (v < trk.lo) begin
        // old minimum becomes the runner-up
        trk.lo_next    = trk.lo;
        trk.lo_next_ok = 1'b1;
        trk.lo         = v;
        trk.lo_hits    = count_t'(1);
      end else if (v == trk.lo) begin
        trk.lo_hits = sat_inc(trk.lo_hits);
      end else if (!trk.lo_next_ok || v < trk.lo_next) begin
        trk.lo_next    = v;
        trk.lo_next_ok = 1'b1;
      end

      if (v > trk.hi) begin
        trk.hi_next    = trk.hi;
        trk.hi_next_ok = 1'b1;
        trk.hi         = v;
        trk.hi_hits    = count_t'(1);
      end else if (v == trk.hi) begin
        trk.hi_hits = sat_inc(trk.hi_hits);
      end else if (!trk.hi_next_ok || v > trk.hi_next) begin
        trk.hi_next    = v;
        trk.hi_next_ok = 1'b1;
      end
    end

    if (last) begin
      trk.open           = 1'b0;
      s.min_value        = trk.lo;
      s.max_value        = trk.hi;
      s.second_min_value = trk.lo_next_ok ? trk.lo_next : trk.lo;
      s.second_max_value = trk.hi_next_ok ? trk.hi_next : trk.hi;
      // constant frame: runner-ups collapse onto the single value
      if (trk.lo == trk.hi) begin
        s.second_min_value = trk.lo;
        s.second_max_value = trk.hi;
      end
      s.min_count = trk.lo_hits;
      s.max_count = trk.hi_hits;
      summary_q.push_back(s);
    end
  endtask

  // Drive one pixel word, entered and left at a falling edge.
  task automatic send_pixel(sample_t v, logic last);
    int gap;
    gap = gaps_on ? $urandom_range(0, STALL_MAX) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    track_pixel(v, last);
    pixels_sent++;
    if (last) frames_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(int px[$]);
    foreach (px[i]) send_pixel(sample_t'(px[i]), i == px.size() - 1);
  endtask

  task automatic note_mismatch(string what, int want, int got);
    faults++;
    if (faults <= REPORT_LIMIT)
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
  endtask

  function automatic sample_t draw_pixel(pixel_mode_t mode, int base);
    int edges[5] = '{-32768, -32767, 0, 32766, 32767};
    case (mode)
      PIX_NARROW: begin
        return sample_t'(base + $urandom_range(0, 3));
      end
      PIX_EDGES: begin
        return sample_t'(edges[$urandom_range(0, 4)]);
      end
      default: begin
        return sample_t'($urandom);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // one-pixel frames: all four values equal the pixel, both counts one
  task automatic test_single_pixel_frames();
    send_pixel(sample_t'(-32768), 1'b1);
    send_pixel(sample_t'(32767), 1'b1);
    send_pixel(sample_t'(0), 1'b1);
    send_pixel(sample_t'(-1), 1'b1);
  endtask

  // constant frames: runner-ups never seen, counts equal frame length
  task automatic test_constant_frames();
    send_frame('{5, 5, 5, 5});
    send_frame('{-32768, -32768, -32768});
  endtask

  // runner-up updates: duplicates of both extrema, displaced extrema,
  // full-range two-value frame, strictly descending frame
  task automatic test_runner_ups();
    send_frame('{3, 1, 1, 7, 7, 2, 1});
    send_frame('{32767, -32768});
    send_frame('{9, 8, 7});
  endtask

  // random frames of mixed length and value spread, idling switched per frame
  task automatic test_random_frames();
    int          start;
    int          len;
    int          base;
    int          pick;
    pixel_mode_t mode;
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      mode    = pixel_mode_t'($urandom_range(0, 2));
      base    = int'($urandom_range(0, 65520)) - 32760;
      pick    = $urandom_range(0, 19);
      if (pick == 0)
        len = $urandom_range(100, 200);
      else if (pick < 4)
        len = 1;
      else
        len = $urandom_range(2, 16);
      for (int i = 0; i < len; i++)
        send_pixel(draw_pixel(mode, base), i == len - 1);
    end
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, compare every summary word in order
  // ---------------------------------------------------------------------------
  initial begin
    int       stall;
    summary_t got;
    summary_t want;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = gaps_on ? $urandom_range(0, STALL_MAX) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got = summary_t'(out_tdata);
      summaries_seen++;
      if (summary_q.size() == 0) begin
        note_mismatch("unexpected summary, min_value", 0, int'(got.min_value));
      end else begin
        want = summary_q.pop_front();
        if (got.min_value !== want.min_value)
          note_mismatch("min_value", int'(want.min_value), int'(got.min_value));
        if (got.second_min_value !== want.second_min_value)
          note_mismatch("second_min_value", int'(want.second_min_value),
                        int'(got.second_min_value));
        if (got.max_value !== want.max_value)
          note_mismatch("max_value", int'(want.max_value), int'(got.max_value));
        if (got.second_max_value !== want.second_max_value)
          note_mismatch("second_max_value", int'(want.second_max_value),
                        int'(got.second_max_value));
        if (got.min_count !== want.min_count)
          note_mismatch("min_count", int'(want.min_count), int'(got.min_count));
        if (got.max_count !== want.max_count)
          note_mismatch("max_count", int'(want.max_count), int'(got.max_count));
      end
      @(negedge clk);
    end
  end

  // Watchdog: no word moving on either side for too long means a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tlast     = 1'b0;
    gaps_on      = 1'b1;
    trk          = '{default: '0};
    quiet_cycles = 0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_single_pixel_frames();
    test_constant_frames();
    test_runner_ups();
    test_random_frames();
    in_tvalid <= 1'b0;

    // drain, then let the pipeline settle to catch stray summaries
    while (summary_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d pixel words in %0d frames (single-pixel, constant, runner-up,",
             pixels_sent, frames_sent);
    $display("random spread and edge values) with idling on both sides; %0d summaries seen.",
             summaries_seen);
    if (faults == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", faults);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- frame_extrema_tracker.f -----
src/fet_pkg.sv
src/fet_update.sv
src/frame_extrema_tracker.sv
verif/tb_frame_extrema_tracker.sv
